@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker module.
// Every check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CHK_NEXT(label, ante, cons, msg) \
    `CHK_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/mlqs_pkg.sv @@
package mlqs_pkg;

    // Commands carried by a request.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_IDLE   = 2'd2;
    localparam logic [1:0] STAT_RAN    = 2'd3;

    // Queue identifiers.
    localparam logic [1:0] Q_HIGH = 2'd0;
    localparam logic [1:0] Q_MED  = 2'd1;
    localparam logic [1:0] Q_LOW  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RR_QUANTUM  = 2'd0;
    localparam logic [1:0] CFG_PHASE_SLOTS = 2'd1;
    localparam logic [1:0] CFG_HIGH_MAX    = 2'd2;
    localparam logic [1:0] CFG_MED_MAX     = 2'd3;

    // One stored process.
    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] arrival;
        logic [7:0]  burst;
        logic [7:0]  prio;
    } t_entry;

endpackage

@@ hw/rtl/multilevel_queue_scheduler.sv @@
// Channel    | Direction | Signals                                        | Handshake
// request    | in        | i_command, i_pid, i_arrival, i_burst,          | i_start high while
//            |           | i_priority_req                                 | o_busy is low
// result     | out       | o_status, o_run_pid, o_queue_id, o_work_left   | o_done, one cycle
// config     | in        | i_cfg_idx, i_cfg_wdata                         | i_cfg_we, no wait
//
// Clear, rejected loads, zero-burst loads, idle ticks and unused commands
// give their result in the cycle after the request is taken.
// A stored load walks from the tail of its queue towards the head, moving the k entries
// with a larger key up by one place (k is at most QUEUE_DEPTH - 1), and writes the new
// entry where the walk stops: at the head, or behind an entry whose key is no larger.
// A tick updates the served entry and, when a finished process leaves its queue, moves
// the m entries behind it down one place; the store has one read and one write port.
// Reset is synchronous and active low; queue contents need no clearing since
// only entries below each fill count are ever read. o_done lasts one cycle and
// the receiver cannot stall it; o_busy is low again in that same cycle.
module multilevel_queue_scheduler #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_pid,
    input  logic [15:0] i_arrival,
    input  logic [7:0]  i_burst,
    input  logic [7:0]  i_priority_req,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_run_pid,
    output logic [1:0]  o_queue_id,
    output logic        o_work_left
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_TICK_RD,
        S_TICK_EVAL,
        S_REM_RD,
        S_REM_WR,
        S_TICK_UPD
    } t_state;

    // The service order runs high, medium, low and wraps round.
    function automatic logic [1:0] next_q(input logic [1:0] q);
        logic [1:0] n;
        case (q)
            mlqs_pkg::Q_HIGH: n = mlqs_pkg::Q_MED;
            mlqs_pkg::Q_MED:  n = mlqs_pkg::Q_LOW;
            default:          n = mlqs_pkg::Q_HIGH;
        endcase
        return n;
    endfunction

    function automatic logic [CW-1:0] cnt_by(input logic [1:0] q, input logic [CW-1:0] hi,
                                             input logic [CW-1:0] md,
                                             input logic [CW-1:0] lo);
        logic [CW-1:0] c;
        case (q)
            mlqs_pkg::Q_HIGH: c = hi;
            mlqs_pkg::Q_MED:  c = md;
            default:          c = lo;
        endcase
        return c;
    endfunction

    // The medium queue is ordered by priority, the others by arrival time.
    function automatic logic [15:0] key_of(input logic [1:0] q, input mlqs_pkg::t_entry e);
        logic [15:0] k;
        if (q == mlqs_pkg::Q_MED) begin
            k = {8'd0, e.prio};
        end else begin
            k = e.arrival;
        end
        return k;
    endfunction

    // Configuration registers.
    logic [3:0] r_rr_quantum;
    logic [5:0] r_phase_slots;
    logic [7:0] r_high_max;
    logic [7:0] r_med_max;

    // Sequencer and scheduling state.
    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt_hi, n_cnt_hi;
    logic [CW-1:0]    r_cnt_md, n_cnt_md;
    logic [CW-1:0]    r_cnt_lo, n_cnt_lo;
    logic [AW-1:0]    r_rr_pos, n_rr_pos;
    logic [3:0]       r_qu_used, n_qu_used;
    logic [1:0]       r_phase, n_phase;
    logic [5:0]       r_slots_used, n_slots_used;
    logic             r_running, n_running;
    logic [1:0]       r_q, n_q;
    logic [AW-1:0]    r_idx, n_idx;
    mlqs_pkg::t_entry r_entry, n_entry;
    logic             r_removed, n_removed;

    // Result registers.
    logic       r_done, n_done;
    logic [1:0] r_status, n_status;
    logic [7:0] r_out_pid, n_out_pid;
    logic [1:0] r_qid, n_qid;
    logic       r_work_left, n_work_left;

    // Store port.
    logic             mem_we;
    logic [MW-1:0]    mem_waddr;
    mlqs_pkg::t_entry mem_wdata;
    logic [MW-1:0]    mem_raddr;
    mlqs_pkg::t_entry mem_rdata;

    // Working values.
    logic [1:0]    in_q;
    logic [CW-1:0] cnt_in;
    logic [CW-1:0] cnt_q;
    logic          any_now;
    logic [1:0]    sel_p1;
    logic [1:0]    sel_p2;
    logic [1:0]    sel_p;
    logic [AW-1:0] tick_idx;
    logic [7:0]    burst_dec;
    logic [CW-1:0] cnt_new_q;
    logic [CW-1:0] hi_after;
    logic [CW-1:0] md_after;
    logic [CW-1:0] lo_after;
    logic          work_after;
    logic [3:0]    qu_inc;
    logic [5:0]    slots_inc;
    logic [CW-1:0] rr_next;

    mlqs_store #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Band classification of an incoming process. Priority zero always falls
    // into the low queue.
    always_comb begin
        if ((i_priority_req != 8'd0) && (i_priority_req <= r_high_max)) begin
            in_q = mlqs_pkg::Q_HIGH;
        end else if ((i_priority_req > r_high_max) && (i_priority_req <= r_med_max)) begin
            in_q = mlqs_pkg::Q_MED;
        end else begin
            in_q = mlqs_pkg::Q_LOW;
        end
    end

    assign cnt_in  = cnt_by(in_q, r_cnt_hi, r_cnt_md, r_cnt_lo);
    assign cnt_q   = cnt_by(r_q, r_cnt_hi, r_cnt_md, r_cnt_lo);
    assign any_now = (r_cnt_hi != '0) || (r_cnt_md != '0) || (r_cnt_lo != '0);

    // A tick serves the first non-empty queue from the current phase onwards.
    assign sel_p1 = next_q(r_phase);
    assign sel_p2 = next_q(sel_p1);
    always_comb begin
        if (cnt_by(r_phase, r_cnt_hi, r_cnt_md, r_cnt_lo) != '0) begin
            sel_p = r_phase;
        end else if (cnt_by(sel_p1, r_cnt_hi, r_cnt_md, r_cnt_lo) != '0) begin
            sel_p = sel_p1;
        end else begin
            sel_p = sel_p2;
        end
    end

    // The round-robin pointer wraps if the queue has shrunk under it.
    always_comb begin
        if (sel_p == mlqs_pkg::Q_HIGH) begin
            tick_idx = (CW'(r_rr_pos) >= r_cnt_hi) ? '0 : r_rr_pos;
        end else begin
            tick_idx = '0;
        end
    end

    assign burst_dec = mem_rdata.burst - 8'd1;

    // End-of-tick bookkeeping, valid in S_TICK_UPD where r_q is the served queue.
    assign cnt_new_q = cnt_q - CW'(r_removed);
    assign hi_after  = (r_q == mlqs_pkg::Q_HIGH) ? cnt_new_q : r_cnt_hi;
    assign md_after  = (r_q == mlqs_pkg::Q_MED)  ? cnt_new_q : r_cnt_md;
    assign lo_after  = (r_q == mlqs_pkg::Q_LOW)  ? cnt_new_q : r_cnt_lo;
    assign work_after = (hi_after != '0) || (md_after != '0) || (lo_after != '0);
    assign qu_inc    = r_qu_used + 4'd1;
    assign slots_inc = r_slots_used + 6'd1;

    always_comb begin
        if (r_removed) begin
            rr_next = CW'(r_rr_pos);
        end else if (qu_inc >= r_rr_quantum) begin
            rr_next = CW'(r_rr_pos) + CW'(1);
        end else begin
            rr_next = CW'(r_rr_pos);
        end
        if (rr_next >= cnt_new_q) begin
            rr_next = '0;
        end
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_cnt_hi     = r_cnt_hi;
        n_cnt_md     = r_cnt_md;
        n_cnt_lo     = r_cnt_lo;
        n_rr_pos     = r_rr_pos;
        n_qu_used    = r_qu_used;
        n_phase      = r_phase;
        n_slots_used = r_slots_used;
        n_running    = r_running;
        n_q          = r_q;
        n_idx        = r_idx;
        n_entry      = r_entry;
        n_removed    = r_removed;
        n_done       = 1'b0;
        n_status     = r_status;
        n_out_pid    = r_out_pid;
        n_qid        = r_qid;
        n_work_left  = r_work_left;
        mem_we       = 1'b0;
        mem_waddr    = {r_q, r_idx};
        mem_wdata    = r_entry;
        mem_raddr    = {r_q, r_idx};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        mlqs_pkg::CMD_LOAD: begin
                            if (r_running || (cnt_in >= CW'(QUEUE_DEPTH))) begin
                                n_done      = 1'b1;
                                n_status    = mlqs_pkg::STAT_REJECT;
                                n_out_pid   = 8'd0;
                                n_qid       = in_q;
                                n_work_left = any_now;
                            end else if (i_burst == 8'd0) begin
                                // Nothing to run, so nothing is stored.
                                n_done      = 1'b1;
                                n_status    = mlqs_pkg::STAT_OK;
                                n_out_pid   = 8'd0;
                                n_qid       = in_q;
                                n_work_left = any_now;
                            end else begin
                                n_entry = '{pid: i_pid, arrival: i_arrival,
                                            burst: i_burst, prio: i_priority_req};
                                n_q     = in_q;
                                n_idx   = cnt_in[AW-1:0];
                                n_state = (cnt_in == '0) ? S_INS_WR : S_INS_RD;
                            end
                        end
                        mlqs_pkg::CMD_TICK: begin
                            if (!any_now) begin
                                n_rr_pos     = '0;
                                n_qu_used    = 4'd0;
                                n_phase      = mlqs_pkg::Q_HIGH;
                                n_slots_used = 6'd0;
                                n_running    = 1'b0;
                                n_done       = 1'b1;
                                n_status     = mlqs_pkg::STAT_IDLE;
                                n_out_pid    = 8'd0;
                                n_qid        = mlqs_pkg::Q_HIGH;
                                n_work_left  = 1'b0;
                            end else begin
                                n_running = 1'b1;
                                n_phase   = sel_p;
                                if (sel_p != r_phase) begin
                                    n_slots_used = 6'd0;
                                end
                                if (sel_p == mlqs_pkg::Q_HIGH) begin
                                    n_rr_pos = tick_idx;
                                end
                                n_q     = sel_p;
                                n_idx   = tick_idx;
                                n_state = S_TICK_RD;
                            end
                        end
                        mlqs_pkg::CMD_CLEAR: begin
                            n_cnt_hi     = '0;
                            n_cnt_md     = '0;
                            n_cnt_lo     = '0;
                            n_rr_pos     = '0;
                            n_qu_used    = 4'd0;
                            n_phase      = mlqs_pkg::Q_HIGH;
                            n_slots_used = 6'd0;
                            n_running    = 1'b0;
                            n_done       = 1'b1;
                            n_status     = mlqs_pkg::STAT_OK;
                            n_out_pid    = 8'd0;
                            n_qid        = mlqs_pkg::Q_HIGH;
                            n_work_left  = 1'b0;
                        end
                        default: begin
                            n_done      = 1'b1;
                            n_status    = mlqs_pkg::STAT_REJECT;
                            n_out_pid   = 8'd0;
                            n_qid       = mlqs_pkg::Q_HIGH;
                            n_work_left = any_now;
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                mem_raddr = {r_q, AW'(r_idx - AW'(1))};
                n_state   = S_INS_CMP;
            end

            S_INS_CMP: begin
                mem_we = 1'b1;
                if (key_of(r_q, mem_rdata) > key_of(r_q, r_entry)) begin
                    // Larger key moves up one place; keep walking down.
                    mem_wdata = mem_rdata;
                    n_idx     = r_idx - AW'(1);
                    n_state   = (r_idx == AW'(1)) ? S_INS_WR : S_INS_RD;
                end else begin
                    mem_wdata   = r_entry;
                    n_state     = S_IDLE;
                    n_done      = 1'b1;
                    n_status    = mlqs_pkg::STAT_OK;
                    n_out_pid   = 8'd0;
                    n_qid       = r_q;
                    n_work_left = 1'b1;
                    case (r_q)
                        mlqs_pkg::Q_HIGH: n_cnt_hi = r_cnt_hi + CW'(1);
                        mlqs_pkg::Q_MED:  n_cnt_md = r_cnt_md + CW'(1);
                        default:          n_cnt_lo = r_cnt_lo + CW'(1);
                    endcase
                end
            end

            S_INS_WR: begin
                mem_we      = 1'b1;
                mem_wdata   = r_entry;
                n_state     = S_IDLE;
                n_done      = 1'b1;
                n_status    = mlqs_pkg::STAT_OK;
                n_out_pid   = 8'd0;
                n_qid       = r_q;
                n_work_left = 1'b1;
                case (r_q)
                    mlqs_pkg::Q_HIGH: n_cnt_hi = r_cnt_hi + CW'(1);
                    mlqs_pkg::Q_MED:  n_cnt_md = r_cnt_md + CW'(1);
                    default:          n_cnt_lo = r_cnt_lo + CW'(1);
                endcase
            end

            S_TICK_RD: begin
                n_state = S_TICK_EVAL;
            end

            S_TICK_EVAL: begin
                n_entry = mem_rdata;
                if (burst_dec != 8'd0) begin
                    mem_we          = 1'b1;
                    mem_wdata       = mem_rdata;
                    mem_wdata.burst = burst_dec;
                    n_removed       = 1'b0;
                    n_state         = S_TICK_UPD;
                end else begin
                    // The process has finished: close the gap behind it.
                    n_removed = 1'b1;
                    n_state   = ((CW'(r_idx) + CW'(1)) < cnt_q) ? S_REM_RD : S_TICK_UPD;
                end
            end

            S_REM_RD: begin
                mem_raddr = {r_q, AW'(r_idx + AW'(1))};
                n_state   = S_REM_WR;
            end

            S_REM_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_idx     = r_idx + AW'(1);
                n_state   = ((CW'(r_idx) + CW'(2)) < cnt_q) ? S_REM_RD : S_TICK_UPD;
            end

            S_TICK_UPD: begin
                n_cnt_hi = hi_after;
                n_cnt_md = md_after;
                n_cnt_lo = lo_after;
                if (r_q == mlqs_pkg::Q_HIGH) begin
                    n_rr_pos  = rr_next[AW-1:0];
                    n_qu_used = (r_removed || (qu_inc >= r_rr_quantum)) ? 4'd0 : qu_inc;
                end
                if ((slots_inc >= r_phase_slots) || (cnt_new_q == '0)) begin
                    n_phase      = next_q(r_q);
                    n_slots_used = 6'd0;
                end else begin
                    n_slots_used = slots_inc;
                end
                if (!work_after) begin
                    n_rr_pos     = '0;
                    n_qu_used    = 4'd0;
                    n_phase      = mlqs_pkg::Q_HIGH;
                    n_slots_used = 6'd0;
                    n_running    = 1'b0;
                end
                n_state     = S_IDLE;
                n_done      = 1'b1;
                n_status    = mlqs_pkg::STAT_RAN;
                n_out_pid   = r_entry.pid;
                n_qid       = r_q;
                n_work_left = work_after;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt_hi     <= '0;
            r_cnt_md     <= '0;
            r_cnt_lo     <= '0;
            r_rr_pos     <= '0;
            r_qu_used    <= 4'd0;
            r_phase      <= mlqs_pkg::Q_HIGH;
            r_slots_used <= 6'd0;
            r_running    <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_hi     <= n_cnt_hi;
            r_cnt_md     <= n_cnt_md;
            r_cnt_lo     <= n_cnt_lo;
            r_rr_pos     <= n_rr_pos;
            r_qu_used    <= n_qu_used;
            r_phase      <= n_phase;
            r_slots_used <= n_slots_used;
            r_running    <= n_running;
            r_done       <= n_done;
        end
        r_q         <= n_q;
        r_idx       <= n_idx;
        r_entry     <= n_entry;
        r_removed   <= n_removed;
        r_status    <= n_status;
        r_out_pid   <= n_out_pid;
        r_qid       <= n_qid;
        r_work_left <= n_work_left;
    end

    // Configuration writes keep only the bits each register holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rr_quantum  <= 4'd4;
            r_phase_slots <= 6'd10;
            r_high_max    <= 8'd5;
            r_med_max     <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mlqs_pkg::CFG_RR_QUANTUM:  r_rr_quantum  <= i_cfg_wdata[3:0];
                mlqs_pkg::CFG_PHASE_SLOTS: r_phase_slots <= i_cfg_wdata[5:0];
                mlqs_pkg::CFG_HIGH_MAX:    r_high_max    <= i_cfg_wdata;
                mlqs_pkg::CFG_MED_MAX:     r_med_max     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_run_pid   = r_out_pid;
    assign o_queue_id  = r_qid;
    assign o_work_left = r_work_left;

endmodule

@@ hw/rtl/mlqs_store.sv @@
// Process store for all three queues: one write port, one read port with
// registered read data. The queue number forms the upper address bits.
module mlqs_store #(
    parameter int QUEUE_DEPTH = 8,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int MW = AW + 2
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [MW-1:0]       i_waddr,
    input  mlqs_pkg::t_entry    i_wdata,
    input  logic [MW-1:0]       i_raddr,
    output mlqs_pkg::t_entry    o_rdata
);

    localparam int WORDS = 2 ** MW;

    mlqs_pkg::t_entry r_mem [WORDS];
    mlqs_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mlqs_checker.sv @@
`include "assert_macros.svh"

// Port-level checks on the scheduler.
module mlqs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic [1:0] i_command,
    input logic       o_busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [7:0] o_run_pid,
    input logic [1:0] o_queue_id,
    input logic       o_work_left
);

    // A taken request either keeps the block busy or answers at once.
    `CHK_NEXT(a_taken_progress, i_start && !o_busy, o_busy || o_done, "request lost")

    // Busy only ever starts from a request.
    `CHK_ASSERT(a_busy_from_start, $rose(o_busy) |-> $past(i_start), "busy without request")

    // Clear answers in the next cycle with nothing left to run.
    `CHK_NEXT(a_clear_result, i_start && !o_busy && (i_command == mlqs_pkg::CMD_CLEAR),
              o_done && (o_status == mlqs_pkg::STAT_OK) && !o_work_left, "bad clear result")

    // An idle tick reports no process, the high queue id and no work left.
    `CHK_ASSERT(a_idle_tick, o_done && (o_status == mlqs_pkg::STAT_IDLE) |->
                (o_run_pid == 8'd0) && (o_queue_id == mlqs_pkg::Q_HIGH) && !o_work_left,
                "idle tick fields")

    // A result comes with the block ready and a real queue number.
    `CHK_ASSERT(a_done_ready, o_done |-> !o_busy && (o_queue_id != 2'd3), "bad result cycle")

endmodule

bind multilevel_queue_scheduler mlqs_checker u_mlqs_checker (.*);
